/* src/lcgsh_pkg.sv */
// ============================================================================
// lcgsh_pkg - shared constants and types for the combined LCG shuffle RNG
// Generator moduli and multipliers, shuffle table sizing, request codes,
// the table write bundle and the table slot function.
// ============================================================================
package lcgsh_pkg;

    // Width of every generator value, table entry and result
    localparam int VAL_W = 31;
    // Width of the generator multipliers
    localparam int MUL_W = 16;
    // Width of the 2^31 folding constants
    localparam int FOLD_W = 8;

    // Shuffle table sizing
    localparam int TABLE_DEPTH = 32;
    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // Warm-up counter runs from TABLE_DEPTH+7 down to zero
    localparam int CNT_W = $clog2(TABLE_DEPTH + 8);

    // Generator 1: x <- 40014*x mod 2147483563
    localparam logic [VAL_W-1:0]  MOD_A  = 31'd2147483563;
    localparam logic [MUL_W-1:0]  MUL_A  = 16'd40014;
    localparam logic [FOLD_W-1:0] FOLD_A = 8'd85;    // 2^31 mod MOD_A
    // Generator 2: y <- 40692*y mod 2147483399
    localparam logic [VAL_W-1:0]  MOD_B  = 31'd2147483399;
    localparam logic [MUL_W-1:0]  MUL_B  = 16'd40692;
    localparam logic [FOLD_W-1:0] FOLD_B = 8'd249;   // 2^31 mod MOD_B

    // Output wraps into 1..OUT_WRAP
    localparam logic [VAL_W-1:0] OUT_WRAP = MOD_A - 31'd1;
    // Output range covered by one table slot
    localparam logic [31:0] BUCKET = 32'd1 + {1'b0, OUT_WRAP} / 32'(TABLE_DEPTH);
    // Reset value of generator 2
    localparam logic [VAL_W-1:0] GEN2_INIT = 31'd123456789;

    // Request opcodes
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // Which generator a modular multiply unit serves
    typedef enum logic {
        GEN_A,
        GEN_B
    } gen_sel_t;

    // One write into the shuffle table
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } tbl_wr_t;

    // Table slot picked by the previous output: floor(x / BUCKET), at most
    // TABLE_DEPTH-1. Each threshold compare is independent.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [VAL_W-1:0] x);
        logic [SLOT_W-1:0] s;
        s = '0;
        for (int k = 1; k < TABLE_DEPTH; k++)
        begin
            if ({1'b0, x} >= 32'(k) * BUCKET)
            begin
                s = SLOT_W'(k);
            end
        end
        return s;
    endfunction

endpackage

/* src/lcgsh_mulmod.sv */
// ============================================================================
// lcgsh_mulmod - two-stage constant modular multiplier
// Stage 1 forms x*mul (47 bits). Stage 2 folds the bits above 2^31 back in
// with 2^31 mod m and finishes with one compare and subtract.
// ============================================================================
module lcgsh_mulmod (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lcgsh_pkg::gen_sel_t              sel,
    input  logic                             en,
    input  logic [lcgsh_pkg::VAL_W-1:0]      x,
    output logic [lcgsh_pkg::VAL_W-1:0]      res
);
    import lcgsh_pkg::*;

    localparam int PROD_W = VAL_W + MUL_W;
    localparam int HF_W   = MUL_W + FOLD_W;

    logic [MUL_W-1:0]  mul;
    logic [FOLD_W-1:0] fold;
    logic [VAL_W-1:0]  modulus;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              v1_reg;
    logic [HF_W-1:0]   hi_fold;
    logic [VAL_W:0]    sum;
    logic [VAL_W:0]    red;
    logic [VAL_W-1:0]  res_reg;

    // Generator constants
    always_comb
    begin
        unique case (sel)
            GEN_A:
            begin
                mul     = MUL_A;
                fold    = FOLD_A;
                modulus = MOD_A;
            end
            GEN_B:
            begin
                mul     = MUL_B;
                fold    = FOLD_B;
                modulus = MOD_B;
            end
            default:
            begin
                mul     = MUL_A;
                fold    = FOLD_A;
                modulus = MOD_A;
            end
        endcase
    end

    // Stage 1: full product
    assign prod_next = PROD_W'(x) * PROD_W'(mul);

    // Stage 2: hi*2^31 + lo == hi*fold + lo, sum stays below twice the modulus
    assign hi_fold = HF_W'(prod_reg[PROD_W-1:VAL_W]) * HF_W'(fold);
    assign sum     = {1'b0, prod_reg[VAL_W-1:0]} + (VAL_W+1)'(hi_fold);
    assign red     = (sum >= {1'b0, modulus}) ? (sum - {1'b0, modulus}) : sum;

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= en;
        end
    end

    // Datapath registers, held between operations
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
        if (v1_reg)
        begin
            res_reg <= red[VAL_W-1:0];
        end
    end

    assign res = res_reg;

endmodule

/* src/lcgsh_table.sv */
// ============================================================================
// lcgsh_table - shuffle table memory
// One write and one registered read per cycle. Per-entry valid bits make
// never-written entries read as zero straight out of reset.
// ============================================================================
module lcgsh_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [lcgsh_pkg::SLOT_W-1:0]      rd_addr,
    output logic [lcgsh_pkg::VAL_W-1:0]       rd_data,
    input  lcgsh_pkg::tbl_wr_t                wr
);
    import lcgsh_pkg::*;

    logic [VAL_W-1:0]       mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [VAL_W-1:0]       rd_data_reg;
    logic                   rd_hit_reg;

    // Memory array and read data
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits and read hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

/* src/combined_lcg_shuffle_rng.sv */
// ============================================================================
// combined_lcg_shuffle_rng - combined LCG generator with shuffle table
// Two multiplicative generators are combined through a 32-entry shuffle
// table indexed by the previous output; one result per request.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------
//   request | req_valid, req_stall | opcode, seed_value
//   result  | rsp_valid, rsp_stall | random_value
//
// In a draw, both generator multipliers and the table read start on the
// accept edge; the result and table write-back follow once the two-stage
// modular multiply has finished.
// A reseed runs TABLE_DEPTH+8 warm-up steps before its draw, each through
// issue, wait and write-back, since each step waits on the previous multiply.
// Reset restores the generator state; the table reads as zero until written.
// A stalled result holds the final step; new requests wait for it to drain.
// ============================================================================
module combined_lcg_shuffle_rng (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          opcode,
    input  logic [lcgsh_pkg::VAL_W-1:0]   seed_value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [lcgsh_pkg::VAL_W-1:0]   random_value
);
    import lcgsh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_ISSUE,
        S_SEED_WAIT,
        S_SEED_WB,
        S_DRAW_ISSUE,
        S_DRAW_WAIT,
        S_DRAW_FINAL
    } state_t;

    state_t           state_reg, state_next;
    logic [VAL_W-1:0] g1_reg, g1_next;
    logic [VAL_W-1:0] g2_reg, g2_next;
    logic [VAL_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [VAL_W-1:0] rsp_value_reg, rsp_value_next;

    logic             draw_issue;
    logic             mul_a_en;
    logic [VAL_W-1:0] res_a;
    logic [VAL_W-1:0] res_b;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0] tbl_data;
    tbl_wr_t          tbl_wr;
    logic [VAL_W-1:0] seed_eff;
    logic [VAL_W:0]   diff;

    // Issue control
    assign draw_issue = ((state_reg == S_IDLE) && req_valid && (opcode == OP_DRAW))
                        || (state_reg == S_DRAW_ISSUE);
    assign mul_a_en   = draw_issue || (state_reg == S_SEED_ISSUE);
    assign slot       = slot_of(last_reg);
    assign seed_eff   = (seed_value == '0) ? VAL_W'(1) : seed_value;

    // Generator 1 multiplier
    lcgsh_mulmod u_mul_a (
        .clk   (clk),
        .rst_n (rst_n),
        .sel   (GEN_A),
        .en    (mul_a_en),
        .x     (g1_reg),
        .res   (res_a)
    );

    // Generator 2 multiplier
    lcgsh_mulmod u_mul_b (
        .clk   (clk),
        .rst_n (rst_n),
        .sel   (GEN_B),
        .en    (draw_issue),
        .x     (g2_reg),
        .res   (res_b)
    );

    // Shuffle table
    lcgsh_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (draw_issue),
        .rd_addr (slot),
        .rd_data (tbl_data),
        .wr      (tbl_wr)
    );

    // Entry minus generator 2, wrapped into 1..OUT_WRAP
    assign diff = (tbl_data <= res_b)
                  ? ({1'b0, tbl_data} + {1'b0, OUT_WRAP} - {1'b0, res_b})
                  : ({1'b0, tbl_data} - {1'b0, res_b});

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_value_next = rsp_value_reg;
        tbl_wr         = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (opcode == OP_RESEED)
                    begin
                        g1_next    = seed_eff;
                        g2_next    = seed_eff;
                        cnt_next   = CNT_W'(TABLE_DEPTH + 7);
                        state_next = S_SEED_ISSUE;
                    end
                    else
                    begin
                        state_next = S_DRAW_WAIT;
                    end
                end
            end
            S_SEED_ISSUE:
            begin
                state_next = S_SEED_WAIT;
            end
            S_SEED_WAIT:
            begin
                state_next = S_SEED_WB;
            end
            S_SEED_WB:
            begin
                // warm-up step; the last TABLE_DEPTH results fill the table
                g1_next = res_a;
                if (cnt_reg < CNT_W'(TABLE_DEPTH))
                begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = cnt_reg[SLOT_W-1:0];
                    tbl_wr.data = res_a;
                end
                if (cnt_reg == '0)
                begin
                    last_next  = res_a;
                    state_next = S_DRAW_ISSUE;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_SEED_ISSUE;
                end
            end
            S_DRAW_ISSUE:
            begin
                state_next = S_DRAW_WAIT;
            end
            S_DRAW_WAIT:
            begin
                state_next = S_DRAW_FINAL;
            end
            S_DRAW_FINAL:
            begin
                // commit only once the result register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    tbl_wr.en      = 1'b1;
                    tbl_wr.addr    = slot;
                    tbl_wr.data    = res_a;
                    g1_next        = res_a;
                    g2_next        = res_b;
                    last_next      = diff[VAL_W-1:0];
                    rsp_value_next = diff[VAL_W-1:0];
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            g1_reg        <= VAL_W'(1);
            g2_reg        <= GEN2_INIT;
            last_reg      <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            g1_reg        <= g1_next;
            g2_reg        <= g2_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        rsp_value_reg <= rsp_value_next;
    end

    assign req_stall    = (state_reg != S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign random_value = rsp_value_reg;

endmodule

/* src/lcgsh_checker.sv */
// ============================================================================
// lcgsh_checker - port-level checks for the combined LCG shuffle RNG
// Watches both channels: result range, one request in flight at a time,
// and result hold under stall.
// ============================================================================
module lcgsh_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [lcgsh_pkg::VAL_W-1:0]   random_value
);
    import lcgsh_pkg::*;

    // Results are always wrapped into 1..OUT_WRAP
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((random_value != '0) && (random_value <= OUT_WRAP)))
        else $error("result out of range");

    // One request at a time: an accepted request stalls the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while busy");

    // A new result only appears while a request is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without a request in flight");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(random_value)))
        else $error("stalled result changed");

endmodule

bind combined_lcg_shuffle_rng lcgsh_checker u_checker (.*);

/* bench/combined_lcg_shuffle_rng_test.sv */
// ============================================================================
// combined_lcg_shuffle_rng_test - self-checking bench for the shuffled RNG
// Drives draw and reseed requests through the valid/stall request channel,
// predicts every result with a software copy of both generators and the
// shuffle table, and compares each result in order. Both channels idle and
// stall at random, including one long result hold-off and drain pauses.
// ============================================================================
module combined_lcg_shuffle_rng_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lcgsh_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_CYCLES  = 500;

    // One pending request; drain asks the sender to wait for all results first
    typedef struct packed {
        logic             op;
        logic [VAL_W-1:0] seed;
        logic             drain;
    } req_item_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    logic             opcode = OP_DRAW;
    logic [VAL_W-1:0] seed_value = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    logic [VAL_W-1:0] random_value;

    req_item_t        pending_reqs[$];
    logic [VAL_W-1:0] expected_values[$];

    // Predicted generator state
    logic [VAL_W-1:0] gen_a;
    logic [VAL_W-1:0] gen_b;
    logic [VAL_W-1:0] prev_out;
    logic [VAL_W-1:0] shuffle[TABLE_DEPTH];

    int total_items = 0;
    int items_accepted = 0;
    int results_seen = 0;
    int fail_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int idle_cycles = 0;

    combined_lcg_shuffle_rng dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .seed_value   (seed_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .random_value (random_value)
    );

    always #5 clk = ~clk;

    // x * a mod m with exact 64-bit arithmetic
    function automatic logic [VAL_W-1:0] mul_mod(input logic [VAL_W-1:0] x,
                                                 input logic [MUL_W-1:0] a,
                                                 input logic [VAL_W-1:0] m);
        longint unsigned p;
        p = (64'(x) * 64'(a)) % 64'(m);
        return VAL_W'(p);
    endfunction

    // Mostly short gaps, a few long ones; none in quiet stretches
    function automatic int pick_gap(input bit quiet, input int busy_pct);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r >= busy_pct)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Advance the predicted state by one request and queue its result
    task automatic predict_value(input logic op, input logic [VAL_W-1:0] seed);
        logic [VAL_W-1:0] s;
        longint unsigned  slot;
        longint           diff;
        if (op == OP_RESEED)
        begin
            s = (seed == '0) ? VAL_W'(1) : seed;
            gen_a = s;
            gen_b = s;
            for (int i = TABLE_DEPTH + 7; i >= 0; i--)
            begin
                gen_a = mul_mod(gen_a, MUL_A, MOD_A);
                if (i < TABLE_DEPTH)
                    shuffle[i] = gen_a;
            end
            prev_out = shuffle[0];
        end
        gen_a = mul_mod(gen_a, MUL_A, MOD_A);
        gen_b = mul_mod(gen_b, MUL_B, MOD_B);
        slot = 64'(prev_out) / 64'(BUCKET);
        if (slot >= TABLE_DEPTH)
            slot = TABLE_DEPTH - 1;
        diff = longint'(64'(shuffle[slot])) - longint'(64'(gen_b));
        shuffle[slot] = gen_a;
        if (diff < 1)
            diff = diff + longint'(64'(OUT_WRAP));
        prev_out = VAL_W'(diff);
        expected_values.push_back(prev_out);
    endtask

    task automatic add_req(input logic op, input logic [VAL_W-1:0] seed, input bit drain);
        req_item_t it;
        it.op = op;
        it.seed = seed;
        it.drain = drain;
        pending_reqs.push_back(it);
        total_items++;
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            opcode <= OP_DRAW;
            seed_value <= '0;
        end
        else
        begin
            bit slot_free;
            req_item_t it;
            slot_free = !req_valid;
            if (req_valid && !req_stall)
            begin
                predict_value(opcode, seed_value);
                items_accepted++;
                slot_free = 1'b1;
            end
            if (slot_free)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain && expected_values.size() != 0))
                begin
                    req_valid <= 1'b0;
                end
                else
                begin
                    it = pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    opcode <= it.op;
                    seed_value <= it.seed;
                    gap_left = pick_gap(((items_accepted / 150) % 4) == 3, 30);
                end
            end
        end
    end

    // Result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            logic [VAL_W-1:0] want;
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (expected_values.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %0d with nothing pending", random_value);
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (random_value !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("random_value mismatch on result %0d: expected %0d got %0d",
                                     results_seen, want, random_value);
                    end
                end
            end
            // one long hold-off lets the block back up into the request side
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= 300)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap(((results_seen / 150) % 4) == 1, 25);
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_stall <= 1'b1;
                end
                else
                begin
                    rsp_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("combined_lcg_shuffle_rng test failed");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int r;
        logic [VAL_W-1:0] s;

        gen_a = VAL_W'(1);
        gen_b = GEN2_INIT;
        prev_out = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            shuffle[i] = '0;

        // draws straight from the reset state
        add_req(OP_DRAW, '0, 1'b0);
        add_req(OP_DRAW, '1, 1'b0);
        add_req(OP_DRAW, VAL_W'(31'h2AAAAAAA), 1'b0);
        // zero seed is taken as one
        add_req(OP_RESEED, '0, 1'b0);
        add_req(OP_DRAW, VAL_W'(31'h55555555), 1'b0);
        add_req(OP_RESEED, VAL_W'(1), 1'b0);
        // largest seed, above both moduli
        add_req(OP_RESEED, '1, 1'b0);
        add_req(OP_DRAW, '0, 1'b0);
        // seed equal to a modulus sticks that generator at zero
        add_req(OP_RESEED, MOD_A, 1'b0);
        add_req(OP_DRAW, '0, 1'b0);
        add_req(OP_DRAW, '1, 1'b0);
        add_req(OP_RESEED, MOD_B, 1'b0);
        add_req(OP_DRAW, '0, 1'b0);
        add_req(OP_DRAW, '1, 1'b0);
        add_req(OP_RESEED, OUT_WRAP, 1'b1);
        add_req(OP_RESEED, MOD_B - VAL_W'(1), 1'b0);
        add_req(OP_RESEED, MOD_A + VAL_W'(1), 1'b0);
        add_req(OP_RESEED, GEN2_INIT, 1'b0);
        add_req(OP_DRAW, '0, 1'b0);
        add_req(OP_DRAW, '0, 1'b0);

        // random mix: mostly draws, some reseeds, a few corner seeds
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            s = VAL_W'($urandom());
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                case ($urandom_range(0, 4))
                    0: s = '0;
                    1: s = '1;
                    2: s = MOD_A;
                    3: s = MOD_B;
                    default: s = VAL_W'(1);
                endcase
            end
            add_req((r < 10) ? OP_RESEED : OP_DRAW, s,
                    (n == 600) || ($urandom_range(0, 199) == 0));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (items_accepted == total_items);
        wait (expected_values.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("combined_lcg_shuffle_rng test passed");
        else
            $display("combined_lcg_shuffle_rng test failed");
        $finish;
    end

endmodule
